### hw/rtl/dswl_pkg.sv
// shared constants, types and helpers for the dds sweep word loader
`default_nettype none

package dswl_pkg;

   localparam int WORD_WIDTH      = 32;
   localparam int CMD_WIDTH       = 3;
   localparam int DATA_WIDTH      = 8;
   localparam int STROBE_WIDTH    = 2;
   localparam int PHASE_WIDTH     = 5;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int COUNT_WIDTH     = 6;
   localparam int JOB_DEPTH       = 2;
   localparam int JOB_PTR_WIDTH   = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_WIDTH   = $clog2(JOB_DEPTH + 1);

   // command codes
   localparam logic [CMD_WIDTH-1:0] CMD_RESET  = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_WRITE  = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_RESEND = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_TICK   = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_REWIND = 3'd4;

   // pin pulse codes
   localparam logic [STROBE_WIDTH-1:0] STB_WCLK  = 2'd0;
   localparam logic [STROBE_WIDTH-1:0] STB_FQUD  = 2'd1;
   localparam logic [STROBE_WIDTH-1:0] STB_RESET = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SERIAL_MODE  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MULT_ENABLE  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PHASE_OFFSET = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POWERED_DOWN = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SWEEP_START  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SWEEP_STOP   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SWEEP_STEP   = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOUNCE_MODE  = 3'd7;

   // index of the final pulse of each sequence
   localparam logic [COUNT_WIDTH-1:0] LOAD_SERIAL_LAST   = 6'd40;
   localparam logic [COUNT_WIDTH-1:0] LOAD_PARALLEL_LAST = 6'd5;
   localparam logic [COUNT_WIDTH-1:0] RST_SERIAL_LAST    = 6'd2;
   localparam logic [COUNT_WIDTH-1:0] RST_PARALLEL_LAST  = 6'd0;

   typedef struct packed {
      logic                   serial_mode;
      logic                   mult_enable;
      logic [PHASE_WIDTH-1:0] phase_offset;
      logic                   powered_down;
      logic [WORD_WIDTH-1:0]  sweep_start;
      logic [WORD_WIDTH-1:0]  sweep_stop;
      logic [WORD_WIDTH-1:0]  sweep_step;
      logic                   bounce_mode;
   } cfg_type;

   typedef struct packed {
      logic                  is_reset;
      logic [WORD_WIDTH-1:0] word;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LOAD,
      BK_RESET
   } back_state_type;

   function automatic logic [DATA_WIDTH-1:0] ctrl_byte(input cfg_type cfg);
      ctrl_byte = {cfg.phase_offset, cfg.powered_down, 1'b0, cfg.mult_enable};
   endfunction

endpackage

`default_nettype wire

### hw/rtl/dswl_req_if.sv
// command channel interface
`default_nettype none

interface dswl_req_if
   import dswl_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [CMD_WIDTH-1:0]  command;
   logic [WORD_WIDTH-1:0] tuning_word;

   modport source (output valid, output command, output tuning_word, input ready);
   modport sink   (input valid, input command, input tuning_word, output ready);
endinterface

`default_nettype wire

### hw/rtl/dswl_rsp_if.sv
// pin pulse channel interface
`default_nettype none

interface dswl_rsp_if
   import dswl_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic [STROBE_WIDTH-1:0] strobe_res;
   logic [DATA_WIDTH-1:0]   data_value;
   logic                    last;
   logic [WORD_WIDTH-1:0]   sent_word;

   modport source (output valid, output strobe_res, output data_value, output last,
                   output sent_word, input ready);
   modport sink   (input valid, input strobe_res, input data_value, input last,
                   input sent_word, output ready);
endinterface

`default_nettype wire

### hw/rtl/dswl_csr.sv
// configuration register file
`default_nettype none

module dswl_csr
   import dswl_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [WORD_WIDTH-1:0]      csr_write_data,
   output cfg_type                         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SERIAL_MODE:  cfg_in.serial_mode  = csr_write_data[0];
            CSR_MULT_ENABLE:  cfg_in.mult_enable  = csr_write_data[0];
            CSR_PHASE_OFFSET: cfg_in.phase_offset = csr_write_data[PHASE_WIDTH-1:0];
            CSR_POWERED_DOWN: cfg_in.powered_down = csr_write_data[0];
            CSR_SWEEP_START:  cfg_in.sweep_start  = csr_write_data;
            CSR_SWEEP_STOP:   cfg_in.sweep_stop   = csr_write_data;
            CSR_SWEEP_STEP:   cfg_in.sweep_step   = csr_write_data;
            CSR_BOUNCE_MODE:  cfg_in.bounce_mode  = csr_write_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hw/rtl/dswl_front.sv
// command front end: accepts beats, updates shadow and sweep state, queues load and reset jobs
`default_nettype none

module dswl_front
   import dswl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   dswl_req_if.sink     req_bus,
   input  wire logic    job_full,
   output logic         job_push,
   output job_type      job_data
);

   logic [WORD_WIDTH-1:0] position_ff, position_in;
   logic                  upward_ff, upward_in;
   logic [WORD_WIDTH-1:0] shadow_ff, shadow_in;

   logic                  accept;
   logic [WORD_WIDTH-1:0] range_lo, range_hi;
   logic signed [WORD_WIDTH+1:0] sum_s, dif_s, cur_s, alt_s, lo_s, hi_s, max_s;
   logic                  out_of_range;
   logic [WORD_WIDTH-1:0] bounced;
   logic                  rewind_up;

   assign req_bus.ready = !job_full;
   assign accept        = req_bus.valid && !job_full;

   always_comb begin
      range_lo  = (cfg.sweep_start < cfg.sweep_stop) ? cfg.sweep_start : cfg.sweep_stop;
      range_hi  = (cfg.sweep_start < cfg.sweep_stop) ? cfg.sweep_stop  : cfg.sweep_start;
      lo_s      = $signed({2'b00, range_lo});
      hi_s      = $signed({2'b00, range_hi});
      max_s     = $signed({2'b00, {WORD_WIDTH{1'b1}}});
      sum_s     = $signed({2'b00, position_ff}) + $signed({2'b00, cfg.sweep_step});
      dif_s     = $signed({2'b00, position_ff}) - $signed({2'b00, cfg.sweep_step});
      cur_s     = upward_ff ? sum_s : dif_s;
      alt_s     = upward_ff ? dif_s : sum_s;
      out_of_range = (cur_s > hi_s) || (cur_s < lo_s);
      // reversed step, clamped to the word range
      if (alt_s < 0) begin
         bounced = '0;
      end else if (alt_s > max_s) begin
         bounced = {WORD_WIDTH{1'b1}};
      end else begin
         bounced = alt_s[WORD_WIDTH-1:0];
      end
      rewind_up = (cfg.sweep_stop >= cfg.sweep_start);
   end

   always_comb begin
      position_in = position_ff;
      upward_in   = upward_ff;
      shadow_in   = shadow_ff;
      job_push    = 1'b0;
      job_data    = '0;
      if (accept) begin
         case (req_bus.command)
            CMD_RESET: begin
               job_push          = 1'b1;
               job_data.is_reset = 1'b1;
            end
            CMD_WRITE: begin
               shadow_in     = req_bus.tuning_word;
               job_push      = 1'b1;
               job_data.word = req_bus.tuning_word;
            end
            CMD_RESEND: begin
               job_push      = 1'b1;
               job_data.word = shadow_ff;
            end
            CMD_TICK: begin
               shadow_in     = position_ff;
               job_push      = 1'b1;
               job_data.word = position_ff;
               if (!out_of_range) begin
                  position_in = cur_s[WORD_WIDTH-1:0];
               end else if (cfg.bounce_mode) begin
                  upward_in   = !upward_ff;
                  position_in = bounced;
               end else begin
                  position_in = cfg.sweep_start;
                  upward_in   = rewind_up;
               end
            end
            CMD_REWIND: begin
               position_in = cfg.sweep_start;
               upward_in   = rewind_up;
            end
            default: begin
               job_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         upward_ff   <= 1'b1;
         shadow_ff   <= '0;
      end else begin
         position_ff <= position_in;
         upward_ff   <= upward_in;
         shadow_ff   <= shadow_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/dswl_job_fifo.sv
// short job queue between front end and pulse sequencer
`default_nettype none

module dswl_job_fifo
   import dswl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   input  wire logic    pop,
   output job_type      head,
   output logic         empty,
   output logic         full
);

   job_type                  entry_ff [JOB_DEPTH];
   logic [JOB_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_WIDTH-1:0] count_ff, count_in;
   logic                     do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == JOB_CNT_WIDTH'(JOB_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == JOB_PTR_WIDTH'(JOB_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == JOB_PTR_WIDTH'(JOB_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/dswl_back.sv
// pulse sequencer: turns queued jobs into W_CLK, FQ_UD and RESET beats
`default_nettype none

module dswl_back
   import dswl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire job_type head,
   input  wire logic    empty,
   output logic         pop,
   dswl_rsp_if.source rsp_bus
);

   back_state_type state_ff, state_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [WORD_WIDTH-1:0]   word_ff, word_in;

   logic                    valid_ff, valid_in;
   logic [STROBE_WIDTH-1:0] strobe_ff, strobe_in;
   logic [DATA_WIDTH-1:0]   data_ff, data_in;
   logic                    last_ff, last_in;
   logic [WORD_WIDTH-1:0]   sent_ff, sent_in;

   logic                    out_free, fire, done;
   logic [COUNT_WIDTH-1:0]  last_idx;
   logic                    pulse_last;
   logic [STROBE_WIDTH-1:0] pulse_strobe;
   logic [DATA_WIDTH-1:0]   pulse_data;
   logic [WORD_WIDTH-1:0]   pulse_word;
   logic [DATA_WIDTH+WORD_WIDTH-1:0] frame;

   assign out_free = !valid_ff || rsp_bus.ready;
   assign fire     = (state_ff != BK_IDLE) && out_free;
   assign done     = fire && pulse_last;
   assign pop      = !empty && ((state_ff == BK_IDLE) || done);

   // next state
   always_comb begin
      state_in = state_ff;
      if (pop) begin
         state_in = head.is_reset ? BK_RESET : BK_LOAD;
      end else if (done) begin
         state_in = BK_IDLE;
      end
   end

   // pulse contents for the current position in the sequence
   always_comb begin
      frame        = {ctrl_byte(cfg), word_ff};
      pulse_strobe = STB_WCLK;
      pulse_data   = '0;
      pulse_word   = word_ff;
      last_idx     = '0;
      case (state_ff)
         BK_LOAD: begin
            last_idx = cfg.serial_mode ? LOAD_SERIAL_LAST : LOAD_PARALLEL_LAST;
            if (count_ff == last_idx) begin
               pulse_strobe = STB_FQUD;
            end else if (cfg.serial_mode) begin
               pulse_data = {{(DATA_WIDTH-1){1'b0}}, frame[count_ff]};
            end else begin
               case (count_ff[2:0])
                  3'd0:    pulse_data = word_ff[7:0];
                  3'd1:    pulse_data = word_ff[15:8];
                  3'd2:    pulse_data = word_ff[23:16];
                  3'd3:    pulse_data = word_ff[31:24];
                  3'd4:    pulse_data = ctrl_byte(cfg);
                  default: pulse_data = '0;
               endcase
            end
         end
         BK_RESET: begin
            last_idx   = cfg.serial_mode ? RST_SERIAL_LAST : RST_PARALLEL_LAST;
            pulse_word = '0;
            if (count_ff == '0) begin
               pulse_strobe = STB_RESET;
            end else if (count_ff == last_idx) begin
               pulse_strobe = STB_FQUD;
            end else begin
               pulse_strobe = STB_WCLK;
            end
         end
         default: begin
            last_idx = '0;
         end
      endcase
      pulse_last = (count_ff == last_idx);
   end

   // counters and output register
   always_comb begin
      count_in  = count_ff;
      word_in   = word_ff;
      valid_in  = valid_ff;
      strobe_in = strobe_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      sent_in   = sent_ff;
      if (pop) begin
         count_in = '0;
         word_in  = head.word;
      end else if (fire) begin
         count_in = count_ff + 1'b1;
      end
      if (fire) begin
         valid_in  = 1'b1;
         strobe_in = pulse_strobe;
         data_in   = pulse_data;
         last_in   = pulse_last;
         sent_in   = pulse_word;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      strobe_ff <= strobe_in;
      data_ff   <= data_in;
      last_ff   <= last_in;
      sent_ff   <= sent_in;
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.strobe_res = strobe_ff;
   assign rsp_bus.data_value = data_ff;
   assign rsp_bus.last       = last_ff;
   assign rsp_bus.sent_word  = sent_ff;

endmodule

`default_nettype wire

### hw/rtl/dds_sweep_word_loader.sv
// DDS load controller: commands in, one beat per W_CLK / FQ_UD / RESET pin pulse out.
//
// req_bus carries a command and a tuning word; rsp_bus carries one beat per pin
// pulse with the data bus value, the word being loaded and a last flag on the
// final pulse of the command. csr_* writes the mode and sweep registers; users must
// do so only while idle, as the block itself does not enforce it. A load sends 41
// beats in serial mode and 6 in parallel mode; a reset command sends 3 or 1; rewind
// and unknown codes send none. Commands are accepted back to back and queued two
// deep behind the front end, which updates the shadow word and sweep position at
// accept time. When the sequencer is free, the first beat of a command passes the
// job queue, the sequencer state and the output register; the sequencer then emits
// one beat per cycle while the receiver takes them, and jobs follow each other
// without a gap. A stalled receiver holds the current beat in the output register
// and freezes the sequencer; the front end keeps accepting until the queue is full.
// Reset clears the registers to zero, the sweep to position zero counting
// upward and the shadow word to zero, and drops all queued work.
`default_nettype none

module dds_sweep_word_loader
   import dswl_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   dswl_req_if.sink                        req_bus,
   dswl_rsp_if.source                      rsp_bus,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [WORD_WIDTH-1:0]      csr_write_data
);

   cfg_type cfg;
   job_type job_push_data;
   job_type job_head;
   logic    job_push, job_pop, job_empty, job_full;

   dswl_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   dswl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_bus  (req_bus),
      .job_full (job_full),
      .job_push (job_push),
      .job_data (job_push_data)
   );

   dswl_job_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_push_data),
      .pop       (job_pop),
      .head      (job_head),
      .empty     (job_empty),
      .full      (job_full)
   );

   dswl_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .head    (job_head),
      .empty   (job_empty),
      .pop     (job_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

### hw/rtl/dswl_checker.sv
// port-level checks on the pulse channel, bound to the top level
`default_nettype none

module dswl_checker
   import dswl_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [STROBE_WIDTH-1:0] rsp_strobe_res,
   input wire logic [DATA_WIDTH-1:0]   rsp_data_value,
   input wire logic                    rsp_last,
   input wire logic [WORD_WIDTH-1:0]   rsp_sent_word
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("pulse beat dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pulse beat shown right after reset");

   a_fqud_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_strobe_res == STB_FQUD |-> rsp_last && rsp_data_value == '0)
      else $error("FQ_UD beat not final or carries data");

   a_reset_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_strobe_res == STB_RESET |->
         rsp_data_value == '0 && rsp_sent_word == '0)
      else $error("RESET beat carries data or word");

   a_strobe_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_strobe_res == STB_WCLK || rsp_strobe_res == STB_FQUD ||
                    rsp_strobe_res == STB_RESET)
      else $error("unknown pulse code");

endmodule

bind dds_sweep_word_loader dswl_checker u_dswl_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_strobe_res (rsp_bus.strobe_res),
   .rsp_data_value (rsp_bus.data_value),
   .rsp_last       (rsp_bus.last),
   .rsp_sent_word  (rsp_bus.sent_word)
);

`default_nettype wire
